@@ rtl/core/msov_pkg.sv @@
`timescale 1ns / 1ps

package msov_pkg;

  // Audio sample rate that the note table is built for.
  localparam int unsigned SAMPLE_RATE_HZ = 44100;

  localparam int unsigned PHASE_W = 24;
  localparam int unsigned STEP_W  = 23;
  localparam int unsigned NOTE_W  = 7;
  localparam int unsigned VOL_W   = 7;

  // Item codes on the opcode field.
  localparam logic [1:0] OP_KEYBOARD   = 2'd0;
  localparam logic [1:0] OP_CONTROLLER = 2'd1;
  localparam logic [1:0] OP_TICK       = 2'd2;

  // MIDI status nibbles, channel nibble stripped.
  localparam logic [3:0] ST_NOTE_OFF = 4'h8;
  localparam logic [3:0] ST_NOTE_ON  = 4'h9;
  localparam logic [3:0] ST_CONTROL  = 4'hB;

  localparam logic [1:0]       FULL_MSG_LEN = 2'd3;
  localparam logic [NOTE_W-1:0] CC_VOLUME   = 7'd2;
  localparam logic [VOL_W-1:0]  VOL_RESET   = 7'd127;

  typedef logic [STEP_W-1:0] step_table_t [128];

  // 2^(k/12) in Q30.
  localparam logic [31:0] SEMITONE_Q30 [12] = '{
    32'd1073741824, 32'd1137589835, 32'd1205234447, 32'd1276901417,
    32'd1352829926, 32'd1433273380, 32'd1518500250, 32'd1608794974,
    32'd1704458901, 32'd1805811301, 32'd1913190429, 32'd2026954652
  };

  localparam logic [63:0] STEP_DEN = 64'(SAMPLE_RATE_HZ) << 12;
  localparam logic [63:0] STEP_MAX = 64'h7F_FFFF;

  // Phase increment per note, worked out at elaboration only.
  function automatic step_table_t build_step_table();
    step_table_t tbl;
    int unsigned m;
    logic [63:0] num;
    logic [63:0] q;
    for (int n = 0; n < 128; n++) begin
      m   = n + 3;
      num = (64'd440 * 64'(SEMITONE_Q30[m % 12])) << (m / 12);
      q   = (num + STEP_DEN / 2) / STEP_DEN;
      if (q > STEP_MAX) begin
        q = STEP_MAX;
      end
      tbl[n] = q[STEP_W-1:0];
    end
    return tbl;
  endfunction

  localparam step_table_t STEP_TABLE = build_step_table();

endpackage

@@ rtl/core/midi_saw_oscillator_voice.sv @@
`timescale 1ns / 1ps

// A tick word's sample passes from the input register through the product register to
// the output register, which drives sample_o; a stall downstream can hold the word in
// any of these registers along the way.
// Throughput: one word per cycle, messages and ticks alike, set by the
// three-register pipeline; a stalled output holds the pipeline back one stage at a time.
// Reset (rst_ni low, asynchronous): phase, step and held note cleared, gate
// closed, volume at full scale (127), all pipeline stages empty.

module midi_saw_oscillator_voice (
  input  logic        clk_i,
  input  logic        rst_ni,

  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [1:0]  opcode_i,
  input  logic [1:0]  msg_length_i,
  input  logic [7:0]  status_byte_i,
  input  logic [6:0]  data_one_i,
  input  logic [6:0]  data_two_i,

  output logic        sample_valid_o,
  input  logic        sample_stall_i,
  output logic signed [23:0] sample_o
);

  localparam int unsigned PW = msov_pkg::PHASE_W;
  localparam int unsigned XW = 31;  // width of the offset product

  // Offset that makes the scaled product non-negative: 127 * 2^23.
  localparam logic [XW-1:0] PROD_OFFSET = 31'(127) << 23;

  // ---------------------------------------------------------------------------
  // Stage 1: input register. Every accepted word lands here first.
  // ---------------------------------------------------------------------------
  logic                       s1_valid_q, s1_valid_d;
  logic [1:0]                 s1_opcode_q;
  logic [1:0]                 s1_len_q;
  logic [3:0]                 s1_status_q;
  logic [msov_pkg::NOTE_W-1:0] s1_d1_q;
  logic [msov_pkg::VOL_W-1:0]  s1_d2_q;

  // Voice state.
  logic [PW-1:0]                phase_q, phase_d;
  logic [msov_pkg::STEP_W-1:0]  step_q, step_d;
  logic [msov_pkg::NOTE_W-1:0]  note_q, note_d;
  logic                         gate_q, gate_d;
  logic [msov_pkg::VOL_W-1:0]   vol_q, vol_d;

  // Stage 2: offset product of a tick. Stage 3: output register.
  logic            s2_valid_q, s2_valid_d;
  logic [XW-1:0]   s2_x_q, s2_x_d;
  logic            s3_valid_q, s3_valid_d;
  logic [PW-1:0]   s3_sample_q, s3_sample_d;

  logic s3_ready;
  logic s2_ready;
  logic s1_is_tick;
  logic s1_go;
  logic in_accept;

  // A stage can load when it is empty or its word leaves in this cycle.
  // Messages never need stage 2, so they retire from stage 1 at once.
  assign s3_ready   = !s3_valid_q || !sample_stall_i;
  assign s2_ready   = !s2_valid_q || s3_ready;
  assign s1_is_tick = (s1_opcode_q == msov_pkg::OP_TICK);
  assign s1_go      = s1_valid_q && (!s1_is_tick || s2_ready);
  assign in_stall_o = s1_valid_q && !s1_go;
  assign in_accept  = in_valid_i && !in_stall_o;

  always_comb begin
    s1_valid_d = s1_valid_q;
    if (in_accept) begin
      s1_valid_d = 1'b1;
    end else if (s1_go) begin
      s1_valid_d = 1'b0;
    end
  end

  // ---------------------------------------------------------------------------
  // Message handling and tick product, between stage 1 and stage 2. A message
  // counts only when all three bytes arrived; opcode 3 falls through untouched.
  // ---------------------------------------------------------------------------
  logic               full_msg;
  logic signed [31:0] prod;

  assign full_msg = (s1_len_q == msov_pkg::FULL_MSG_LEN);
  assign prod     = $signed(phase_q) * $signed({1'b0, vol_q});

  always_comb begin
    phase_d    = phase_q;
    step_d     = step_q;
    note_d     = note_q;
    gate_d     = gate_q;
    vol_d      = vol_q;
    s2_valid_d = s2_valid_q;
    s2_x_d     = s2_x_q;

    if (s2_ready) begin
      s2_valid_d = 1'b0;
    end

    if (s1_go) begin
      case (s1_opcode_q)
        msov_pkg::OP_TICK: begin
          // The sample sees the state as it is now; the phase then moves on.
          s2_valid_d = 1'b1;
          s2_x_d     = gate_q ? (prod[XW-1:0] + PROD_OFFSET) : PROD_OFFSET;
          phase_d    = phase_q + {1'b0, step_q};
        end
        msov_pkg::OP_KEYBOARD: begin
          if (full_msg && s1_status_q == msov_pkg::ST_NOTE_ON) begin
            note_d = s1_d1_q;
            step_d = msov_pkg::STEP_TABLE[s1_d1_q];
            gate_d = 1'b1;
          end else if (full_msg && s1_status_q == msov_pkg::ST_NOTE_OFF &&
                       note_q == s1_d1_q) begin
            gate_d = 1'b0;
          end
        end
        msov_pkg::OP_CONTROLLER: begin
          if (full_msg && s1_status_q == msov_pkg::ST_CONTROL &&
              s1_d1_q == msov_pkg::CC_VOLUME) begin
            vol_d = s1_d2_q;
          end
        end
        default: begin
        end
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Division by 127, between stage 2 and stage 3. 1/127 is expanded as
  // 1/128 + 1/128^2 + ..., which falls short by at most four; the remainder
  // is then under 5 * 127 and a short compare chain tops the quotient up.
  // Removing the offset afterwards turns the floor of the offset value into
  // the floor of the signed product, i.e. rounding toward negative infinity.
  // ---------------------------------------------------------------------------
  logic [PW-1:0] q_est;
  logic [XW-1:0] rem_full;
  logic [9:0]    rem;
  logic [2:0]    corr;
  logic [PW-1:0] q_fix;

  assign q_est = s2_x_q[XW-1:7] + PW'(s2_x_q[XW-1:14]) + PW'(s2_x_q[XW-1:21]) +
                 PW'(s2_x_q[XW-1:28]);
  assign rem_full = s2_x_q - {q_est, 7'b0} + {7'b0, q_est};
  assign rem      = rem_full[9:0];
  assign corr     = 3'(rem >= 10'd127) + 3'(rem >= 10'd254) +
                    3'(rem >= 10'd381) + 3'(rem >= 10'd508);
  assign q_fix    = q_est + PW'(corr);

  always_comb begin
    s3_valid_d  = s3_valid_q;
    s3_sample_d = s3_sample_q;
    if (s3_ready) begin
      s3_valid_d = s2_valid_q;
      if (s2_valid_q) begin
        // Subtracting 2^23 from a value below 2^24 flips the top bit.
        s3_sample_d = {~q_fix[PW-1], q_fix[PW-2:0]};
      end
    end
  end

  assign sample_valid_o = s3_valid_q;
  assign sample_o       = $signed(s3_sample_q);

  // ---------------------------------------------------------------------------
  // Registers
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s2_valid_q <= 1'b0;
      s3_valid_q <= 1'b0;
      phase_q    <= '0;
      step_q     <= '0;
      note_q     <= '0;
      gate_q     <= 1'b0;
      vol_q      <= msov_pkg::VOL_RESET;
    end else begin
      s1_valid_q <= s1_valid_d;
      s2_valid_q <= s2_valid_d;
      s3_valid_q <= s3_valid_d;
      phase_q    <= phase_d;
      step_q     <= step_d;
      note_q     <= note_d;
      gate_q     <= gate_d;
      vol_q      <= vol_d;
    end
  end

  // Payload registers carry no reset.
  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      s1_opcode_q <= opcode_i;
      s1_len_q    <= msg_length_i;
      s1_status_q <= status_byte_i[7:4];
      s1_d1_q     <= data_one_i;
      s1_d2_q     <= data_two_i;
    end
    s2_x_q      <= s2_x_d;
    s3_sample_q <= s3_sample_d;
  end

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  a_stall_needs_word: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> s1_valid_q && s1_is_tick)
    else $error("input stalled without a blocked tick in stage 1");

  a_phase_advance: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_go && s1_is_tick) |=> phase_q == $past(phase_q + {1'b0, step_q}))
    else $error("phase did not advance by the step on a tick");

  a_phase_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(s1_go && s1_is_tick) |=> $stable(phase_q))
    else $error("phase moved without a tick");

  a_remainder_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s2_valid_q |-> rem_full < 31'd635)
    else $error("quotient estimate outside its correction range");

  a_s2_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s2_valid_q && !s3_ready) |=> s2_valid_q && $stable(s2_x_q))
    else $error("product stage lost a blocked word");

endmodule
